FILE: rtl/qkve_pkg.sv
`default_nettype none

package qkve_pkg;

    // progress of the decimal conversion inside the value token
    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_INT,
        PH_FRAC,
        PH_STOP
    } number_phase_t;

    // configuration register indexes
    localparam logic [1:0] REG_KEY_FIRST  = 2'd0;
    localparam logic [1:0] REG_KEY_REST   = 2'd1;
    localparam logic [1:0] REG_KEY_LENGTH = 2'd2;

    localparam int          KEY_CHARS         = 14;
    localparam int          MAX_TOKEN_CHARS   = 14;
    localparam logic [3:0]  POSITION_OVERLONG = 4'd15;

    localparam logic [7:0]  QUOTE_CHAR = 8'h22;
    localparam logic [7:0]  POINT_CHAR = 8'h2E;
    localparam logic [7:0]  PLUS_CHAR  = 8'h2B;
    localparam logic [7:0]  MINUS_CHAR = 8'h2D;
    localparam logic [7:0]  ZERO_CHAR  = 8'h30;
    localparam logic [7:0]  NINE_CHAR  = 8'h39;

    localparam logic [2:0]  MAX_FRACTION_DIGITS = 3'd6;
    localparam logic [19:0] INT_PART_MAX        = 20'd65535;

    // fraction scaled to six digits, binary fraction = floor(f6 * 2^16 / 10^6)
    // = floor(f6 * 1024 / 15625), estimated by a reciprocal then corrected once
    localparam logic [13:0] FRAC_DIVISOR = 14'd15625;
    localparam logic [26:0] RECIP_DIV    = 27'd70368744;   // floor(2^40 / 15625)
    localparam int          RECIP_SHIFT  = 30;

    // weight of the next fraction digit once scaled to six digits
    function automatic logic [16:0] frac_weight(input logic [2:0] count);
        logic [16:0] w;
        case (count)
            3'd0:    w = 17'd100000;
            3'd1:    w = 17'd10000;
            3'd2:    w = 17'd1000;
            3'd3:    w = 17'd100;
            3'd4:    w = 17'd10;
            3'd5:    w = 17'd1;
            default: w = 17'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/quoted_key_value_extractor.sv
// quoted_key_value_extractor
//
// Scans a text record, one byte per beat on the s_ channel, for double-quoted
// tokens. The token after the first token equal to the configured key is
// converted as a decimal number and given out on the m_ channel as signed
// Q16.16 with m_outcome 0. A record that ends (s_end_of_record on its last
// beat) without such a value gives one beat with m_outcome 1 and value 0.
// At most one result beat per record.
// Key registers are written through the cfg_ channel (always ready): index 0
// key characters 0..7, index 1 characters 8..13, index 2 key length. The user
// must write them only while the block is idle; the block does not enforce it.
// Throughput: one text byte per cycle while s_ready is high. The scan registers
// update on each accepted byte; the result then passes a four-register pipeline
// (reciprocal multiply, correction, saturation) before m_valid rises. Each
// pipeline stage holds when the next one is full and stalled; s_ready only
// drops when the incoming byte would create a result and the first stage
// cannot take it, so scanning carries on while a result waits.
// Reset (aresetn low, synchronous) clears the scan state, the key registers
// and the pipeline; nothing is lost or repeated under back-pressure.

`default_nettype none

module quoted_key_value_extractor
    import qkve_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_text_byte,
    input  wire logic               s_end_of_record,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_number_value,
    output logic                    m_outcome,

    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data
);

    // ---------------------------------------------------------------
    // key registers
    // ---------------------------------------------------------------
    logic [63:0] key_first_reg;
    logic [47:0] key_rest_reg;
    logic [3:0]  key_length_reg;
    logic [7:0]  key_chars [KEY_CHARS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_first_reg  <= '0;
            key_rest_reg   <= '0;
            key_length_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_KEY_FIRST:  key_first_reg  <= cfg_data;
                REG_KEY_REST:   key_rest_reg   <= cfg_data[47:0];
                REG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                default: ;      // unused index, write dropped
            endcase
        end
    end

    // key characters 0..7 from the first word, 8..13 from the second
    always_comb begin
        for (int i = 0; i < KEY_CHARS; i++) begin
            if (i < 8) begin
                key_chars[i] = key_first_reg[8*i +: 8];
            end else begin
                key_chars[i] = key_rest_reg[8*(i-8) +: 8];
            end
        end
    end

    // ---------------------------------------------------------------
    // scan state
    // ---------------------------------------------------------------
    logic          inside_quotes_reg,  inside_quotes_next;
    logic [3:0]    token_position_reg, token_position_next;
    logic          still_matching_reg, still_matching_next;
    logic          key_seen_reg,       key_seen_next;
    logic          answer_given_reg,   answer_given_next;
    number_phase_t number_phase_reg,   number_phase_next;
    logic          negative_sign_reg,  negative_sign_next;
    logic [15:0]   integer_part_reg,   integer_part_next;
    logic [19:0]   frac_scaled_reg,    frac_scaled_next;   // fraction digits scaled to 10^6
    logic [2:0]    fraction_count_reg, fraction_count_next;

    logic          res_produce;        // this byte creates a result beat
    logic          res_missing;        // that beat reports not-found
    logic          in_accept;

    logic          is_digit;
    logic          is_space;
    logic [3:0]    digit_val;
    logic [19:0]   int_times_ten;
    logic [20:0]   frac_step;

    assign is_digit  = (s_text_byte >= ZERO_CHAR) && (s_text_byte <= NINE_CHAR);
    assign is_space  = s_text_byte inside {8'h20, [8'h09:8'h0D]};
    assign digit_val = s_text_byte[3:0];

    // integer_part * 10 + digit
    assign int_times_ten = 20'({integer_part_reg, 3'b000}) + 20'({integer_part_reg, 1'b0})
                         + 20'(digit_val);
    assign frac_step     = 21'(digit_val) * 21'(frac_weight(fraction_count_reg));

    always_comb begin
        inside_quotes_next  = inside_quotes_reg;
        token_position_next = token_position_reg;
        still_matching_next = still_matching_reg;
        key_seen_next       = key_seen_reg;
        answer_given_next   = answer_given_reg;
        number_phase_next   = number_phase_reg;
        negative_sign_next  = negative_sign_reg;
        integer_part_next   = integer_part_reg;
        frac_scaled_next    = frac_scaled_reg;
        fraction_count_next = fraction_count_reg;
        res_produce         = 1'b0;
        res_missing         = 1'b0;

        if (!answer_given_reg) begin
            if (!inside_quotes_reg) begin
                if (s_text_byte == QUOTE_CHAR) begin
                    inside_quotes_next  = 1'b1;
                    token_position_next = '0;
                    still_matching_next = 1'b1;
                    number_phase_next   = PH_SPACE;
                    negative_sign_next  = 1'b0;
                    integer_part_next   = '0;
                    frac_scaled_next    = '0;
                    fraction_count_next = '0;
                end
            end else if (s_text_byte == QUOTE_CHAR) begin
                inside_quotes_next = 1'b0;
                if (key_seen_reg) begin
                    res_produce       = 1'b1;
                    answer_given_next = 1'b1;
                end else if (still_matching_reg && token_position_reg == key_length_reg) begin
                    key_seen_next = 1'b1;
                end
            end else begin
                // number conversion of the value token
                if (key_seen_reg) begin
                    case (number_phase_reg)
                        PH_SPACE, PH_SIGNED, PH_INT: begin
                            if (is_digit) begin
                                integer_part_next = (int_times_ten > INT_PART_MAX) ?
                                                    16'hFFFF : int_times_ten[15:0];
                                number_phase_next = PH_INT;
                            end else if (s_text_byte == POINT_CHAR) begin
                                number_phase_next = PH_FRAC;
                            end else if (number_phase_reg == PH_SPACE && is_space) begin
                                number_phase_next = PH_SPACE;
                            end else if (number_phase_reg == PH_SPACE &&
                                         (s_text_byte == PLUS_CHAR ||
                                          s_text_byte == MINUS_CHAR)) begin
                                negative_sign_next = (s_text_byte == MINUS_CHAR);
                                number_phase_next  = PH_SIGNED;
                            end else begin
                                number_phase_next = PH_STOP;
                            end
                        end
                        PH_FRAC: begin
                            if (is_digit) begin
                                if (fraction_count_reg < MAX_FRACTION_DIGITS) begin
                                    frac_scaled_next    = frac_scaled_reg + frac_step[19:0];
                                    fraction_count_next = fraction_count_reg + 3'd1;
                                end
                            end else begin
                                number_phase_next = PH_STOP;
                            end
                        end
                        default: ;
                    endcase
                end
                // on-the-fly key compare
                if (token_position_reg < 4'(MAX_TOKEN_CHARS)) begin
                    if (token_position_reg >= key_length_reg ||
                        key_chars[token_position_reg] != s_text_byte) begin
                        still_matching_next = 1'b0;
                    end
                    token_position_next = token_position_reg + 4'd1;
                end else begin
                    still_matching_next = 1'b0;
                    token_position_next = POSITION_OVERLONG;
                end
            end
        end

        if (s_end_of_record) begin
            if (!answer_given_next) begin
                res_produce = 1'b1;
                res_missing = 1'b1;
            end
            inside_quotes_next  = 1'b0;
            token_position_next = '0;
            still_matching_next = 1'b1;
            key_seen_next       = 1'b0;
            answer_given_next   = 1'b0;
            number_phase_next   = PH_SPACE;
            negative_sign_next  = 1'b0;
            integer_part_next   = '0;
            frac_scaled_next    = '0;
            fraction_count_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inside_quotes_reg  <= 1'b0;
            token_position_reg <= '0;
            still_matching_reg <= 1'b1;
            key_seen_reg       <= 1'b0;
            answer_given_reg   <= 1'b0;
            number_phase_reg   <= PH_SPACE;
            negative_sign_reg  <= 1'b0;
            integer_part_reg   <= '0;
            frac_scaled_reg    <= '0;
            fraction_count_reg <= '0;
        end else if (in_accept) begin
            inside_quotes_reg  <= inside_quotes_next;
            token_position_reg <= token_position_next;
            still_matching_reg <= still_matching_next;
            key_seen_reg       <= key_seen_next;
            answer_given_reg   <= answer_given_next;
            number_phase_reg   <= number_phase_next;
            negative_sign_reg  <= negative_sign_next;
            integer_part_reg   <= integer_part_next;
            frac_scaled_reg    <= frac_scaled_next;
            fraction_count_reg <= fraction_count_next;
        end
    end

    // ---------------------------------------------------------------
    // result pipeline, each stage advances when the next has room
    // ---------------------------------------------------------------
    logic        s1_valid_reg, s2_valid_reg, s3_valid_reg, m_valid_reg;
    logic        s1_ready, s2_ready, s3_ready, out_ready;

    logic        s1_missing_reg, s2_missing_reg, s3_missing_reg;
    logic        s1_neg_reg, s2_neg_reg, s3_neg_reg;
    logic [15:0] s1_int_reg, s2_int_reg, s3_int_reg;
    logic [19:0] s1_f6_reg, s2_f6_reg;
    logic [15:0] s2_quot_reg;      // quotient estimate, one low at most
    logic [15:0] s3_frac_reg;      // Q0.16 fraction

    logic [46:0] recip_prod;
    logic [29:0] div_num;
    logic [29:0] div_back;
    logic [29:0] div_rem;
    logic [15:0] quot_fixed;

    logic [31:0] mag;
    logic [31:0] mag_neg_sat;
    logic [31:0] value_next;
    logic signed [31:0] m_number_value_reg;
    logic        m_outcome_reg;

    assign out_ready = !m_valid_reg  || m_ready;
    assign s3_ready  = !s3_valid_reg || out_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;

    // bytes that create no result never wait on the pipeline
    assign s_ready   = !res_produce || s1_ready;
    assign in_accept = s_valid && s_ready;

    assign recip_prod = 47'(s1_f6_reg) * 47'(RECIP_DIV);

    assign div_num    = {s2_f6_reg, 10'b0};
    assign div_back   = 30'(s2_quot_reg) * 30'(FRAC_DIVISOR);
    assign div_rem    = div_num - div_back;
    assign quot_fixed = (div_rem >= 30'(FRAC_DIVISOR)) ? s2_quot_reg + 16'd1 : s2_quot_reg;

    // magnitude, then saturation to the signed range
    assign mag         = {s3_int_reg, s3_frac_reg};
    assign mag_neg_sat = (mag > 32'h8000_0000) ? 32'h8000_0000 : mag;
    always_comb begin
        if (s3_neg_reg) begin
            value_next = 32'd0 - mag_neg_sat;
        end else begin
            value_next = (mag > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag;
        end
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s1_ready) begin
                s1_valid_reg <= in_accept && res_produce;
            end
            if (s2_ready) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (out_ready) begin
                m_valid_reg <= s3_valid_reg;
            end
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s1_ready) begin
            s1_missing_reg <= res_missing;
            s1_neg_reg     <= res_missing ? 1'b0  : negative_sign_reg;
            s1_int_reg     <= res_missing ? 16'd0 : integer_part_reg;
            s1_f6_reg      <= res_missing ? 20'd0 : frac_scaled_reg;
        end
        if (s2_ready) begin
            s2_missing_reg <= s1_missing_reg;
            s2_neg_reg     <= s1_neg_reg;
            s2_int_reg     <= s1_int_reg;
            s2_f6_reg      <= s1_f6_reg;
            s2_quot_reg    <= recip_prod[RECIP_SHIFT +: 16];
        end
        if (s3_ready) begin
            s3_missing_reg <= s2_missing_reg;
            s3_neg_reg     <= s2_neg_reg;
            s3_int_reg     <= s2_int_reg;
            s3_frac_reg    <= quot_fixed;
        end
        if (out_ready) begin
            m_outcome_reg      <= s3_missing_reg;
            m_number_value_reg <= signed'(value_next);
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_outcome      = m_outcome_reg;
    assign m_number_value = m_number_value_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------

    // end of record always leaves the scanner back at its start
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_end_of_record |=>
            !inside_quotes_reg && !key_seen_reg && !answer_given_reg)
        else $error("scan state not cleared after end of record");

    // an answer is only given once the key has been seen
    assert property (@(posedge aclk) disable iff (!aresetn)
        answer_given_reg |-> key_seen_reg)
        else $error("answer given without key");

    // an overlong token can never match
    assert property (@(posedge aclk) disable iff (!aresetn)
        token_position_reg == POSITION_OVERLONG |-> !still_matching_reg)
        else $error("overlong token still matching");

    // not-found beats carry a zero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_outcome |-> m_number_value == 32'sd0)
        else $error("not-found beat with non-zero value");

endmodule

`default_nettype wire

FILE: tb/lookup_checker.sv
`default_nettype none

module lookup_checker
    import qkve_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire logic [7:0]         s_text_byte,
    input  wire logic               s_end_of_record,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire logic signed [31:0] m_number_value,
    input  wire logic               m_outcome,
    input  wire logic               cfg_valid,
    input  wire logic               cfg_ready,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [63:0]        cfg_data,
    output int                      errors,
    output int                      pending,
    output int                      found_count,
    output int                      missing_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OUTCOME_FOUND   = 1'b0;
    localparam logic OUTCOME_MISSING = 1'b1;

    typedef struct packed {
        logic signed [31:0] value;
        logic               outcome;
    } lookup_result_t;

    lookup_result_t expected_results[$];

    // key registers as last written
    logic [63:0] key_lo;
    logic [47:0] key_hi;
    logic [3:0]  key_len;

    // scan state
    bit            in_token;
    logic [3:0]    tok_pos;
    bit            tok_match;
    bit            key_matched;
    bit            answered;
    number_phase_t phase;
    bit            negative;
    logic [15:0]   int_acc;
    logic [19:0]   frac_acc;
    logic [2:0]    frac_n;

    function automatic logic [7:0] key_at(input logic [3:0] pos);
        int idx;
        idx = pos;
        if (idx < 8)
            return key_lo[8*idx +: 8];
        if (idx < KEY_CHARS)
            return key_hi[8*(idx-8) +: 8];
        return 8'h00;
    endfunction

    function automatic void restart_number();
        phase    = PH_SPACE;
        negative = 1'b0;
        int_acc  = '0;
        frac_acc = '0;
        frac_n   = '0;
    endfunction

    function automatic void restart_record();
        in_token    = 1'b0;
        tok_pos     = '0;
        tok_match   = 1'b1;
        key_matched = 1'b0;
        answered    = 1'b0;
        restart_number();
    endfunction

    function automatic void number_char(input logic [7:0] c);
        bit          digit;
        bit          blank;
        int unsigned acc;
        digit = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
        blank = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
        case (phase)
            PH_SPACE, PH_SIGNED, PH_INT: begin
                if (digit) begin
                    acc = int_acc * 10 + (c - ZERO_CHAR);
                    int_acc = (acc > 65535) ? 16'hFFFF : acc[15:0];
                    phase = PH_INT;
                end else if (c == POINT_CHAR) begin
                    phase = PH_FRAC;
                end else if (phase == PH_SPACE && blank) begin
                    // leading white space is skipped
                end else if (phase == PH_SPACE && (c == PLUS_CHAR || c == MINUS_CHAR)) begin
                    negative = (c == MINUS_CHAR);
                    phase = PH_SIGNED;
                end else begin
                    phase = PH_STOP;
                end
            end
            PH_FRAC: begin
                if (digit) begin
                    if (frac_n < MAX_FRACTION_DIGITS) begin
                        frac_acc = frac_acc * 10 + (c - ZERO_CHAR);
                        frac_n++;
                    end
                end else begin
                    phase = PH_STOP;
                end
            end
            default: ;
        endcase
    endfunction

    // signed q16.16 of the digits gathered so far, saturated
    function automatic logic [31:0] q16_value();
        logic [63:0] scale;
        logic [63:0] frac;
        logic [63:0] mag;
        scale = 64'd1;
        for (int k = 0; k < frac_n; k++)
            scale = scale * 10;
        frac = ({44'd0, frac_acc} << 16) / scale;
        mag  = ({48'd0, int_acc} << 16) + frac;
        if (negative) begin
            if (mag > 64'h8000_0000)
                mag = 64'h8000_0000;
            return ~mag[31:0] + 32'd1;
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic void scan_char(input logic [7:0] c, input logic last);
        lookup_result_t r;
        if (!answered) begin
            if (!in_token) begin
                if (c == QUOTE_CHAR) begin
                    in_token  = 1'b1;
                    tok_pos   = '0;
                    tok_match = 1'b1;
                    restart_number();
                end
            end else if (c == QUOTE_CHAR) begin
                in_token = 1'b0;
                if (key_matched) begin
                    r.value   = q16_value();
                    r.outcome = OUTCOME_FOUND;
                    expected_results.push_back(r);
                    found_count++;
                    answered = 1'b1;
                end else if (tok_match && tok_pos == key_len) begin
                    key_matched = 1'b1;
                end
            end else begin
                if (key_matched)
                    number_char(c);
                if (tok_pos < MAX_TOKEN_CHARS) begin
                    if (tok_pos >= key_len || key_at(tok_pos) != c)
                        tok_match = 1'b0;
                    tok_pos++;
                end else begin
                    tok_match = 1'b0;
                    tok_pos   = POSITION_OVERLONG;
                end
            end
        end
        if (last) begin
            if (!answered) begin
                r.value   = '0;
                r.outcome = OUTCOME_MISSING;
                expected_results.push_back(r);
                missing_count++;
            end
            restart_record();
        end
    endfunction

    initial begin
        errors        = 0;
        pending       = 0;
        found_count   = 0;
        missing_count = 0;
    end

    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            key_lo  = '0;
            key_hi  = '0;
            key_len = '0;
            restart_record();
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KEY_FIRST:  key_lo  = cfg_data;
                    REG_KEY_REST:   key_hi  = cfg_data[47:0];
                    REG_KEY_LENGTH: key_len = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, value %0d outcome %0d",
                             $time, m_number_value, m_outcome);
                end else begin
                    want = expected_results.pop_front();
                    if (m_outcome !== want.outcome) begin
                        errors++;
                        $display("%0t: outcome mismatch, expected %0d got %0d",
                                 $time, want.outcome, m_outcome);
                    end
                    if (m_number_value !== want.value) begin
                        errors++;
                        $display("%0t: number_value mismatch, expected %0d got %0d",
                                 $time, want.value, m_number_value);
                    end
                end
            end
            if (s_valid && s_ready)
                scan_char(s_text_byte, s_end_of_record);
        end
        pending <= expected_results.size();
    end

endmodule

`default_nettype wire

FILE: tb/testbench.sv
`default_nettype none

module testbench
    import qkve_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // shapes of a token built from the current key
    typedef enum int {
        EXACT_KEY,
        ALTERED_KEY,
        LONGER_KEY,
        SHORTER_KEY,
        OVERLONG_KEY
    } key_shape_t;

    localparam int PHASE_COUNT = 8;
    localparam int PHASE_BYTES = 250;
    localparam int SETTLE_CYCLES = 8;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [7:0]         s_text_byte;
    logic               s_end_of_record;
    logic               m_valid;
    logic               m_ready;
    logic signed [31:0] m_number_value;
    logic               m_outcome;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [63:0]        cfg_data;

    int errors;
    int pending;
    int found_count;
    int missing_count;

    // text of the record about to be sent, and the key it is built around
    logic [7:0] record_bytes[$];
    logic [7:0] key_chars[KEY_CHARS];
    int         key_count;

    // calm switches off all idling near the end, idle_on gates sender gaps per record
    bit calm;
    bit idle_on;
    int beats_sent;
    int records_sent;
    int phase_bytes;
    int settings_used;

    quoted_key_value_extractor uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_number_value  (m_number_value),
        .m_outcome       (m_outcome),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    lookup_checker lookup_chk (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_text_byte     (s_text_byte),
        .s_end_of_record (s_end_of_record),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_number_value  (m_number_value),
        .m_outcome       (m_outcome),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .errors          (errors),
        .pending         (pending),
        .found_count     (found_count),
        .missing_count   (missing_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // safety net, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side back-pressure: stretches of random stalls alternate with quiet stretches
    initial begin
        int stretch;
        bit quiet;
        m_ready <= 1'b1;
        forever begin
            stretch = $urandom_range(20, 200);
            quiet = ($urandom_range(0, 3) == 0);
            repeat (stretch) begin
                @(posedge aclk);
                if (!quiet && !calm && $urandom_range(0, 3) == 0) begin
                    m_ready <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    // any byte but the quote
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == QUOTE_CHAR);
        return b;
    endfunction

    function automatic logic [7:0] digit_byte();
        return ZERO_CHAR + 8'($urandom_range(0, 9));
    endfunction

    // space or one of tab, line feed, vertical tab, form feed, carriage return
    function automatic logic [7:0] blank_byte();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 0) ? 8'h20 : 8'(8 + pick);
    endfunction

    function automatic void push_text(input string text);
        for (int i = 0; i < text.len(); i++)
            record_bytes.push_back(text[i]);
    endfunction

    function automatic void add_filler();
        repeat ($urandom_range(0, 3)) record_bytes.push_back(plain_byte());
    endfunction

    // quoted token of random length, now and then past the token limit
    function automatic void add_random_token();
        record_bytes.push_back(QUOTE_CHAR);
        repeat ($urandom_range(0, 17)) record_bytes.push_back(plain_byte());
        record_bytes.push_back(QUOTE_CHAR);
    endfunction

    // the key itself or a near miss of it
    function automatic void add_key_token(input key_shape_t shape);
        int         n;
        int         p;
        int         target;
        int         start;
        logic [7:0] b;
        n = (key_count > KEY_CHARS) ? KEY_CHARS : key_count;
        p = (n > 0) ? $urandom_range(0, n - 1) : 0;
        record_bytes.push_back(QUOTE_CHAR);
        start = record_bytes.size();
        for (int i = 0; i < n; i++) begin
            if (shape == SHORTER_KEY && i == n - 1)
                break;
            b = key_chars[i];
            if (shape == ALTERED_KEY && i == p)
                do b = plain_byte(); while (b == key_chars[i]);
            record_bytes.push_back(b);
        end
        if (shape == LONGER_KEY || (shape == ALTERED_KEY && n == 0))
            record_bytes.push_back(plain_byte());
        if (shape == OVERLONG_KEY) begin
            target = $urandom_range(MAX_TOKEN_CHARS + 1, MAX_TOKEN_CHARS + 3);
            while (record_bytes.size() - start < target)
                record_bytes.push_back(plain_byte());
        end
        record_bytes.push_back(QUOTE_CHAR);
    endfunction

    // decimal text: blanks, sign, integer and fraction digits, odd trailing bytes
    function automatic void add_number_text();
        int shape;
        shape = $urandom_range(0, 9);
        if (shape == 0) begin
            // not a number at all
            repeat ($urandom_range(0, 6)) record_bytes.push_back(plain_byte());
            return;
        end
        repeat ($urandom_range(0, 2)) record_bytes.push_back(blank_byte());
        case ($urandom_range(0, 2))
            1: record_bytes.push_back(PLUS_CHAR);
            2: record_bytes.push_back(MINUS_CHAR);
            default: ;
        endcase
        if (shape == 1) begin
            // values around the saturation points
            case ($urandom_range(0, 3))
                0: push_text("32767");
                1: push_text("32768");
                2: push_text("65535");
                default: push_text("65536");
            endcase
        end else begin
            repeat ($urandom_range(0, 7)) record_bytes.push_back(digit_byte());
        end
        if ($urandom_range(0, 2) != 0) begin
            record_bytes.push_back(POINT_CHAR);
            repeat ($urandom_range(0, 9)) record_bytes.push_back(digit_byte());
        end
        if ($urandom_range(0, 3) == 0) begin
            record_bytes.push_back(plain_byte());
            if ($urandom_range(0, 1) == 1)
                record_bytes.push_back(digit_byte());
        end
    endfunction

    function automatic void add_value_token();
        record_bytes.push_back(QUOTE_CHAR);
        add_number_text();
        record_bytes.push_back(QUOTE_CHAR);
    endfunction

    // mostly well-formed key/value records, some cut short, some pure noise
    function automatic void build_record();
        int kind;
        int cut;
        record_bytes.delete();
        kind = $urandom_range(0, 19);
        if (kind >= 17) begin
            repeat ($urandom_range(1, 30))
                record_bytes.push_back(($urandom_range(0, 5) == 0) ?
                                       QUOTE_CHAR : 8'($urandom_range(0, 255)));
            return;
        end
        add_filler();
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) == 1)
                add_random_token();
            else
                add_key_token(key_shape_t'($urandom_range(1, 4)));
            add_filler();
        end
        add_key_token(EXACT_KEY);
        add_filler();
        add_value_token();
        // text after the answer, which the block must ignore
        if ($urandom_range(0, 1) == 1) begin
            add_filler();
            add_random_token();
            add_key_token(EXACT_KEY);
            add_value_token();
        end
        // record cut anywhere, possibly inside the key or the value
        if (kind >= 14) begin
            cut = $urandom_range(1, record_bytes.size());
            while (record_bytes.size() > cut)
                void'(record_bytes.pop_back());
        end
    endfunction

    // one text beat; valid stays up unless a random gap follows
    task automatic send_beat(input logic [7:0] b, input logic last);
        s_text_byte     <= b;
        s_end_of_record <= last;
        s_valid         <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        beats_sent++;
        phase_bytes++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    task automatic send_record();
        for (int i = 0; i < record_bytes.size(); i++)
            send_beat(record_bytes[i], i == record_bytes.size() - 1);
        records_sent++;
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // all three key registers back to back, unused upper bits filled with junk
    task automatic program_key();
        logic [63:0] first_word;
        logic [63:0] rest_word;
        logic [63:0] len_word;
        first_word = {$urandom, $urandom};
        rest_word  = {$urandom, $urandom};
        len_word   = {$urandom, $urandom};
        for (int i = 0; i < 8; i++)
            first_word[8*i +: 8] = key_chars[i];
        for (int i = 0; i < KEY_CHARS - 8; i++)
            rest_word[8*i +: 8] = key_chars[8 + i];
        len_word[3:0] = 4'(key_count);
        write_reg(REG_KEY_FIRST, first_word);
        write_reg(REG_KEY_REST, rest_word);
        write_reg(REG_KEY_LENGTH, len_word);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // drop valid, wait for every answer, then let the result pipeline drain
    task automatic settle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aresetn         <= 1'b0;
        s_valid         <= 1'b0;
        s_text_byte     <= 8'h00;
        s_end_of_record <= 1'b0;
        cfg_valid       <= 1'b0;
        cfg_index       <= REG_KEY_FIRST;
        cfg_data        <= '0;
        calm          = 1'b0;
        idle_on       = 1'b0;
        beats_sent    = 0;
        records_sent  = 0;
        phase_bytes   = 0;
        settings_used = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: empty key over all-ones key registers
        foreach (key_chars[i])
            key_chars[i] = 8'hFF;
        key_count = 0;
        program_key();
        // empty token matches the empty key, minus zero closes on the end mark
        record_bytes.delete();
        push_text("\"\"\"-0\"");
        send_record();
        // integer overflow, seven fraction digits, a byte after the answer
        record_bytes.delete();
        push_text("\"\"\" 70000.1234567\"x");
        send_record();
        // one-beat record of the top byte value, nothing found
        record_bytes = '{8'hFF};
        send_record();
        settle();

        // random phases, each under its own key
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            foreach (key_chars[i])
                key_chars[i] = plain_byte();
            case (phase)
                0: key_count = KEY_CHARS;
                1: key_count = KEY_CHARS + 1;           // longer than any token can match
                2: begin
                    foreach (key_chars[i])
                        key_chars[i] = 8'hFF;
                    key_count = KEY_CHARS;
                end
                3: begin
                    key_chars[0] = 8'h00;
                    key_count = 1;
                end
                default: key_count = $urandom_range(0, KEY_CHARS);
            endcase
            program_key();
            calm = (phase == PHASE_COUNT - 1);
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES) begin
                build_record();
                idle_on = !calm && ($urandom_range(0, 3) != 0);
                send_record();
            end
            settle();
        end

        $display("%0d text beats in %0d records under %0d key settings",
                 beats_sent, records_sent, settings_used);
        $display("%0d found values and %0d not-found answers predicted",
                 found_count, missing_count);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire

FILE: quoted_key_value_extractor.f
rtl/qkve_pkg.sv
rtl/quoted_key_value_extractor.sv
tb/lookup_checker.sv
tb/testbench.sv
